// File: design/bmio_pkg.sv
// Shared types and constants for the banked memory and I/O decoder.
package bmio_pkg;

    typedef enum logic [2:0] {
        TGT_MEM   = 3'd0,
        TGT_NONE  = 3'd1,
        TGT_ACIA  = 3'd2,
        TGT_UART  = 3'd3,
        TGT_DISK  = 3'd4,
        TGT_TIMER = 3'd5,
        TGT_BANK  = 3'd6
    } target_t;

    typedef enum logic [1:0] {
        CFG_LARGE_BANK_MODE = 2'd0,
        CFG_SERIAL_KIND     = 2'd1,
        CFG_DISK_PRESENT    = 2'd2,
        CFG_TIMER_PRESENT   = 2'd3
    } cfg_index_t;

    localparam int unsigned CPU_AW  = 16;
    localparam int unsigned PHYS_AW = 20;

    localparam logic [7:0]         IO_WINDOW_PAGE = 8'hFE;
    localparam logic [PHYS_AW-1:0] LOW_RAM_BASE   = 20'h18000;
    localparam logic [7:0]         BANK_SEL_REG   = 8'h38;
    localparam logic [5:0]         PAGE_REG_ROW   = 6'h1E;  // 0x78-0x7B
    localparam logic [5:0]         PAGING_EN_ROW  = 6'h1F;  // 0x7C-0x7F
    localparam logic [6:0]         ACIA_ROW       = 7'h50;  // 0xA0-0xA1
    localparam logic [4:0]         UART_ROW       = 5'h18;  // 0xC0-0xC7
    localparam logic [4:0]         DISK_ROW       = 5'h02;  // 0x10-0x17
    localparam logic [4:0]         TIMER_ROW      = 5'h0C;  // 0x60-0x67
    localparam logic [5:0]         FIRST_RW_PAGE  = 6'h20;

    typedef struct packed {
        logic large_bank_mode;
        logic serial_kind;
        logic disk_present;
        logic timer_present;
    } cfg_t;

    typedef struct packed {
        logic [1:0]      high_bank;
        logic [3:0][5:0] page_table;
        logic            paging_on;
    } bank_state_t;

    typedef struct packed {
        logic       high_bank_we;
        logic       page_we;
        logic [1:0] page_idx;
        logic       paging_we;
        logic [7:0] data;
    } bank_update_t;

    typedef struct packed {
        logic                op;
        logic [CPU_AW-1:0]   cpu_address;
        logic [7:0]          write_byte;
        logic                debug_access;
    } access_t;

    typedef struct packed {
        target_t             target;
        logic [PHYS_AW-1:0]  physical_address;
        logic [2:0]          device_register;
        logic                memory_write;
    } result_t;

endpackage

// File: design/bmio_ifs.sv
// Channel interfaces: bus access items, result items and configuration writes.
interface bmio_access_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] cpu_address;
    logic [7:0]  write_byte;
    logic        debug_access;

    modport source (output valid, op, cpu_address, write_byte, debug_access, input ready);
    modport sink   (input valid, op, cpu_address, write_byte, debug_access, output ready);
endinterface

interface bmio_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [19:0] physical_address;
    logic [2:0]  device_register;
    logic        memory_write;

    modport source (output valid, target, physical_address, device_register, memory_write,
                    input ready);
    modport sink   (input valid, target, physical_address, device_register, memory_write,
                    output ready);
endinterface

interface bmio_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/bmio_state_regs.sv
// Configuration registers and bank-control state of the decoder.
module bmio_state_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    bmio_cfg_if.sink               cfg,
    input  logic                   update_en,
    input  bmio_pkg::bank_update_t update,
    output bmio_pkg::cfg_t         cfg_state,
    output bmio_pkg::bank_state_t  bank_state
);

    bmio_pkg::cfg_t        cfg_reg;
    bmio_pkg::cfg_t        cfg_next;
    bmio_pkg::bank_state_t bank_reg;
    bmio_pkg::bank_state_t bank_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (bmio_pkg::cfg_index_t'(cfg.index))
                bmio_pkg::CFG_LARGE_BANK_MODE: cfg_next.large_bank_mode = cfg.data;
                bmio_pkg::CFG_SERIAL_KIND:     cfg_next.serial_kind     = cfg.data;
                bmio_pkg::CFG_DISK_PRESENT:    cfg_next.disk_present    = cfg.data;
                bmio_pkg::CFG_TIMER_PRESENT:   cfg_next.timer_present   = cfg.data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        bank_next = bank_reg;
        if (update_en)
        begin
            if (update.high_bank_we)
            begin
                bank_next.high_bank = update.data[1:0];
            end
            if (update.page_we)
            begin
                bank_next.page_table[update.page_idx] = update.data[5:0];
            end
            if (update.paging_we)
            begin
                bank_next.paging_on = update.data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= '{large_bank_mode: 1'b0, serial_kind: 1'b0,
                          disk_present: 1'b0, timer_present: 1'b1};
            bank_reg <= '0;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            bank_reg <= bank_next;
        end
    end

    assign cfg_state  = cfg_reg;
    assign bank_state = bank_reg;

endmodule

// File: design/bmio_decode.sv
// Combinational decode of one access: I/O window, bank registers and memory mapping.
module bmio_decode (
    input  bmio_pkg::access_t      access,
    input  bmio_pkg::cfg_t         cfg_state,
    input  bmio_pkg::bank_state_t  bank_state,
    output bmio_pkg::result_t      result,
    output bmio_pkg::bank_update_t update
);

    logic       in_window;
    logic [7:0] lo;
    logic       is_acia;
    logic       is_uart;
    logic       is_disk;
    logic       is_tmr;
    logic [5:0] page;
    logic       wr;

    assign wr        = access.op;
    assign lo        = access.cpu_address[7:0];
    assign in_window = access.cpu_address[15:8] == bmio_pkg::IO_WINDOW_PAGE;
    assign is_acia   = !cfg_state.serial_kind && lo[7:1] == bmio_pkg::ACIA_ROW;
    assign is_uart   = cfg_state.serial_kind && lo[7:3] == bmio_pkg::UART_ROW;
    assign is_disk   = cfg_state.disk_present && lo[7:3] == bmio_pkg::DISK_ROW;
    assign is_tmr    = cfg_state.timer_present && lo[7:3] == bmio_pkg::TIMER_ROW;
    assign page      = bank_state.page_table[access.cpu_address[15:14]];

    always_comb
    begin
        result        = '{target: bmio_pkg::TGT_NONE, physical_address: '0,
                          device_register: 3'd0, memory_write: 1'b0};
        update        = '0;
        update.data   = access.write_byte;
        update.page_idx = lo[1:0];

        if (in_window)
        begin
            if (!wr)
            begin
                priority if (access.debug_access)
                begin
                    result.target = bmio_pkg::TGT_NONE;
                end
                else if (is_acia)
                begin
                    result.target          = bmio_pkg::TGT_ACIA;
                    result.device_register = {2'b00, lo[0]};
                end
                else if (is_uart)
                begin
                    result.target          = bmio_pkg::TGT_UART;
                    result.device_register = lo[2:0];
                end
                else if (is_disk)
                begin
                    result.target          = bmio_pkg::TGT_DISK;
                    result.device_register = lo[2:0];
                end
                else if (is_tmr)
                begin
                    result.target          = bmio_pkg::TGT_TIMER;
                    result.device_register = lo[2:0];
                end
                else
                begin
                    result.target = bmio_pkg::TGT_NONE;
                end
            end
            else
            begin
                // Write decode order differs from reads: the bank registers
                // take priority over the UART and the timer.
                priority if (is_acia)
                begin
                    result.target          = bmio_pkg::TGT_ACIA;
                    result.device_register = {2'b00, lo[0]};
                end
                else if (is_disk)
                begin
                    result.target          = bmio_pkg::TGT_DISK;
                    result.device_register = lo[2:0];
                end
                else if (lo == bmio_pkg::BANK_SEL_REG)
                begin
                    result.target          = bmio_pkg::TGT_BANK;
                    result.device_register = lo[2:0];
                    update.high_bank_we    = 1'b1;
                end
                else if (lo[7:2] == bmio_pkg::PAGE_REG_ROW)
                begin
                    result.target          = bmio_pkg::TGT_BANK;
                    result.device_register = lo[2:0];
                    update.page_we         = 1'b1;
                end
                else if (lo[7:2] == bmio_pkg::PAGING_EN_ROW)
                begin
                    result.target          = bmio_pkg::TGT_BANK;
                    result.device_register = lo[2:0];
                    update.paging_we       = 1'b1;
                end
                else if (is_uart)
                begin
                    result.target          = bmio_pkg::TGT_UART;
                    result.device_register = lo[2:0];
                end
                else if (is_tmr)
                begin
                    result.target          = bmio_pkg::TGT_TIMER;
                    result.device_register = lo[2:0];
                end
                else
                begin
                    result.target = bmio_pkg::TGT_NONE;
                end
            end
        end
        else if (!cfg_state.large_bank_mode)
        begin
            if (!access.cpu_address[15])
            begin
                result.target           = bmio_pkg::TGT_MEM;
                result.physical_address = bmio_pkg::LOW_RAM_BASE
                                        + {4'h0, access.cpu_address};
                result.memory_write     = wr;
            end
            else if (bank_state.high_bank == 2'd0 && wr)
            begin
                result.target = bmio_pkg::TGT_NONE;
            end
            else
            begin
                result.target           = bmio_pkg::TGT_MEM;
                result.physical_address = {3'b000, bank_state.high_bank,
                                           access.cpu_address[14:0]};
                result.memory_write     = wr;
            end
        end
        else if (!bank_state.paging_on)
        begin
            // Paging off: writes are blocked and reads see the ROM page.
            if (!wr)
            begin
                result.target           = bmio_pkg::TGT_MEM;
                result.physical_address = {6'h00, access.cpu_address[13:0]};
            end
        end
        else if (page < bmio_pkg::FIRST_RW_PAGE && wr)
        begin
            result.target = bmio_pkg::TGT_NONE;
        end
        else
        begin
            result.target           = bmio_pkg::TGT_MEM;
            result.physical_address = {page, access.cpu_address[13:0]};
            result.memory_write     = wr;
        end
    end

endmodule

// File: design/banked_memory_and_io_decoder.sv
// Top level of the banked memory and I/O decoder: input register, decode, result register.
//
//  channel  | role   | payload
//  ---------+--------+-------------------------------------------------------------
//  access   | sink   | op, cpu_address, write_byte, debug_access
//  result   | source | target, physical_address, device_register, memory_write
//  cfg      | sink   | index, data (always ready)
//
// One item per cycle while the result register can drain; an item passes through the
// input register and then the result register, from which its result is offered.
// Bank-register writes update the mapping state as the item leaves the input
// register, so the next item already decodes with the new state.
// A stalled result holds its register; the input register stays open while the result
// register can drain. Reset clears the valid flags and bank state and sets config defaults.
module banked_memory_and_io_decoder (
    input  logic           clk,
    input  logic           rst_n,
    bmio_access_if.sink    access,
    bmio_result_if.source  result,
    bmio_cfg_if.sink       cfg
);

    logic                  stage_valid_reg;
    bmio_pkg::access_t     stage_reg;
    logic                  out_valid_reg;
    bmio_pkg::result_t     out_reg;
    logic                  out_load;
    logic                  stage_load;
    bmio_pkg::result_t     dec_result;
    bmio_pkg::bank_update_t dec_update;
    bmio_pkg::cfg_t        cfg_state;
    bmio_pkg::bank_state_t bank_state;

    assign out_load     = stage_valid_reg && (!out_valid_reg || result.ready);
    assign access.ready = !stage_valid_reg || out_load;
    assign stage_load   = access.valid && access.ready;

    bmio_state_regs u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .update_en  (out_load),
        .update     (dec_update),
        .cfg_state  (cfg_state),
        .bank_state (bank_state)
    );

    bmio_decode u_decode (
        .access     (stage_reg),
        .cfg_state  (cfg_state),
        .bank_state (bank_state),
        .result     (dec_result),
        .update     (dec_update)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (access.ready)
            begin
                stage_valid_reg <= access.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load)
        begin
            stage_reg <= '{op: access.op, cpu_address: access.cpu_address,
                           write_byte: access.write_byte, debug_access: access.debug_access};
        end
        if (out_load)
        begin
            out_reg <= dec_result;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.target           = out_reg.target;
    assign result.physical_address = out_reg.physical_address;
    assign result.device_register  = out_reg.device_register;
    assign result.memory_write     = out_reg.memory_write;

`ifndef ASSERT_OFF
    a_write_only_memory: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.memory_write |-> out_reg.target == bmio_pkg::TGT_MEM)
        else $error("memory_write set for a result that is not a memory access");

    a_addr_zero_off_memory: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.target != bmio_pkg::TGT_MEM |-> out_reg.physical_address == '0)
        else $error("physical address nonzero on a non-memory result");

    a_reg_only_devices: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.target == bmio_pkg::TGT_MEM
                          || out_reg.target == bmio_pkg::TGT_NONE)
        |-> out_reg.device_register == 3'd0)
        else $error("device register offset given for memory or none");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stage_valid_reg))
        else $error("result appeared without an item in the input register");

    a_state_changes_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(bank_state) |-> $past(out_load && stage_reg.op))
        else $error("bank state changed without a bank register write");
`endif

endmodule
